/* hw/rtl/clns_pkg.sv */
`timescale 1ns / 1ps
// Package of the character LCD nibble sequencer: command codes, control types and the
// microprogram table. It depends on nothing and is used by every module of the block.
package clns_pkg;

  typedef enum logic [2:0] {
    CMD_DATA   = 3'd0,
    CMD_INSTR  = 3'd1,
    CMD_CURSOR = 3'd2,
    CMD_INIT   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  typedef enum logic {
    K_BYTE = 1'b0,
    K_WAIT = 1'b1
  } kind_e;

  localparam int unsigned PcW = 5;

  localparam logic [PcW-1:0] EntryByte  = PcW'(0);
  localparam logic [PcW-1:0] EntryClear = PcW'(1);
  localparam logic [PcW-1:0] EntryInit  = PcW'(3);

  localparam logic [6:0] HoldMax     = 7'd100;
  localparam logic [6:0] StrobeReset = 7'd1;
  localparam logic [1:0] SubLast     = 2'd3;

  typedef struct packed {
    kind_e      kind;
    logic       use_req;
    logic [7:0] value;
    logic [6:0] wait_ms;
    logic       last;
  } word_t;

  typedef struct packed {
    logic       load;
    cmd_e       cmd;
    logic       emit;
    logic       wait_step;
    logic       use_req;
    logic [7:0] value;
    logic       lo_half;
    logic       en;
    logic [6:0] wait_ms;
    logic       last;
  } ctrl_t;

  function automatic word_t mk(input kind_e kind, input logic use_req,
                               input logic [7:0] value, input logic [6:0] wait_ms,
                               input logic last);
    word_t w;
    w.kind    = kind;
    w.use_req = use_req;
    w.value   = value;
    w.wait_ms = wait_ms;
    w.last    = last;
    return w;
  endfunction

  // One word per byte transfer or wait. A byte word covers its four strobe steps.
  function automatic word_t clns_rom(input logic [PcW-1:0] addr);
    word_t w;
    unique case (addr)
      5'd0:    w = mk(K_BYTE, 1'b1, 8'h00, 7'd0,  1'b1);
      5'd1:    w = mk(K_BYTE, 1'b0, 8'h01, 7'd0,  1'b0);
      5'd2:    w = mk(K_WAIT, 1'b0, 8'h00, 7'd2,  1'b1);
      5'd3:    w = mk(K_WAIT, 1'b0, 8'h00, 7'd50, 1'b0);
      5'd4:    w = mk(K_BYTE, 1'b0, 8'h03, 7'd0,  1'b0);
      5'd5:    w = mk(K_WAIT, 1'b0, 8'h00, 7'd5,  1'b0);
      5'd6:    w = mk(K_BYTE, 1'b0, 8'h03, 7'd0,  1'b0);
      5'd7:    w = mk(K_WAIT, 1'b0, 8'h00, 7'd1,  1'b0);
      5'd8:    w = mk(K_BYTE, 1'b0, 8'h03, 7'd0,  1'b0);
      5'd9:    w = mk(K_WAIT, 1'b0, 8'h00, 7'd10, 1'b0);
      5'd10:   w = mk(K_BYTE, 1'b0, 8'h02, 7'd0,  1'b0);
      5'd11:   w = mk(K_WAIT, 1'b0, 8'h00, 7'd10, 1'b0);
      5'd12:   w = mk(K_BYTE, 1'b0, 8'h28, 7'd0,  1'b0);
      5'd13:   w = mk(K_WAIT, 1'b0, 8'h00, 7'd1,  1'b0);
      5'd14:   w = mk(K_BYTE, 1'b0, 8'h08, 7'd0,  1'b0);
      5'd15:   w = mk(K_WAIT, 1'b0, 8'h00, 7'd1,  1'b0);
      5'd16:   w = mk(K_BYTE, 1'b0, 8'h01, 7'd0,  1'b0);
      5'd17:   w = mk(K_WAIT, 1'b0, 8'h00, 7'd1,  1'b0);
      5'd18:   w = mk(K_BYTE, 1'b0, 8'h06, 7'd0,  1'b0);
      5'd19:   w = mk(K_WAIT, 1'b0, 8'h00, 7'd1,  1'b0);
      5'd20:   w = mk(K_BYTE, 1'b0, 8'h0C, 7'd0,  1'b1);
      default: w = mk(K_WAIT, 1'b0, 8'h00, 7'd0,  1'b1);
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/clns_if.sv */
`timescale 1ns / 1ps
// Channel interfaces of the character LCD nibble sequencer: requests in, pin steps out
// and the strobe time write channel. They depend on nothing.
interface clns_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] byte_value;
  logic       cursor_row;
  logic [5:0] cursor_column;
  modport source(output valid, command, byte_value, cursor_row, cursor_column, input ready);
  modport sink(input valid, command, byte_value, cursor_row, cursor_column, output ready);
endinterface

interface clns_step_if;
  logic       valid;
  logic       ready;
  logic       drive_pins;
  logic       register_select;
  logic [3:0] bus_nibble;
  logic       enable_level;
  logic [6:0] hold_ms;
  logic       last_step;
  modport source(output valid, drive_pins, register_select, bus_nibble, enable_level,
                 hold_ms, last_step, input ready);
  modport sink(input valid, drive_pins, register_select, bus_nibble, enable_level,
               hold_ms, last_step, output ready);
endinterface

interface clns_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] strobe_hold_ms;
  modport source(output valid, strobe_hold_ms, input ready);
  modport sink(input valid, strobe_hold_ms, output ready);
endinterface

/* hw/rtl/char_lcd_nibble_sequencer.sv */
`timescale 1ns / 1ps
// Top level of the character LCD nibble sequencer for a 4-bit character LCD bus.
// It depends on clns_pkg, the channel interfaces, clns_useq and clns_dpath.

// Each request is expanded into pin steps, one step per clock cycle while the step channel
// takes them: a data, instruction or set cursor request gives four steps, clear gives five
// and initialize forty-five. The next request is taken in the cycle that produces the last
// step of the current one, so back-to-back byte writes follow each other directly; the
// microcode sequencer issues one step a cycle into a single output register. Unknown
// command codes are taken and dropped. The strobe time register may be written at any
// time the block is idle and holds 1 ms after reset; values above 100 are held as 100 ms.
module char_lcd_nibble_sequencer (
  input  logic  clk_i,
  input  logic  rst_ni,
  clns_req_if.sink    req_i,
  clns_step_if.source step_o,
  clns_cfg_if.sink    cfg_i
);
  import clns_pkg::*;

  ctrl_t ctrl;
  logic  out_adv;

  assign cfg_i.ready = 1'b1;

  clns_useq u_useq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_command_i (req_i.command),
    .req_ready_o   (req_i.ready),
    .out_adv_i     (out_adv),
    .ctrl_o        (ctrl)
  );

  clns_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .byte_value_i      (req_i.byte_value),
    .cursor_row_i      (req_i.cursor_row),
    .cursor_column_i   (req_i.cursor_column),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_data_i        (cfg_i.strobe_hold_ms),
    .out_ready_i       (step_o.ready),
    .out_adv_o         (out_adv),
    .out_valid_o       (step_o.valid),
    .drive_pins_o      (step_o.drive_pins),
    .register_select_o (step_o.register_select),
    .bus_nibble_o      (step_o.bus_nibble),
    .enable_level_o    (step_o.enable_level),
    .hold_ms_o         (step_o.hold_ms),
    .last_step_o       (step_o.last_step)
  );

endmodule

/* hw/rtl/clns_useq.sv */
`timescale 1ns / 1ps
// Microcode sequencer: program counter, strobe step counter and request acceptance.
// It depends on clns_pkg for the microprogram table and the control types.
module clns_useq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic [2:0]         req_command_i,
  output logic               req_ready_o,
  input  logic               out_adv_i,
  output clns_pkg::ctrl_t    ctrl_o
);
  import clns_pkg::*;

  state_e         state_q, state_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic [1:0]     sub_q, sub_d;
  word_t          word;
  logic           known;
  logic [PcW-1:0] entry;
  logic           emit, byte_done, finishing, accept;

  always_comb begin
    known = 1'b1;
    entry = EntryByte;
    unique case (req_command_i)
      CMD_DATA, CMD_INSTR, CMD_CURSOR: entry = EntryByte;
      CMD_CLEAR: entry = EntryClear;
      CMD_INIT:  entry = EntryInit;
      default:   known = 1'b0;
    endcase
  end

  assign word        = clns_rom(pc_q);
  assign emit        = (state_q == ST_RUN) && out_adv_i;
  assign byte_done   = (word.kind == K_WAIT) || (sub_q == SubLast);
  assign finishing   = emit && byte_done && word.last;
  assign req_ready_o = (state_q == ST_IDLE) || finishing;
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    sub_d   = sub_q;
    priority if (accept && known) begin
      state_d = ST_RUN;
      pc_d    = entry;
      sub_d   = 2'd0;
    end else if (finishing) begin
      state_d = ST_IDLE;
    end else if (emit) begin
      if (byte_done) begin
        pc_d  = pc_q + PcW'(1);
        sub_d = 2'd0;
      end else begin
        sub_d = sub_q + 2'd1;
      end
    end else begin
      state_d = state_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      sub_q   <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      sub_q   <= sub_d;
    end
  end

  always_comb begin
    ctrl_o.load      = accept && known;
    ctrl_o.cmd       = cmd_e'(req_command_i);
    ctrl_o.emit      = emit;
    ctrl_o.wait_step = (word.kind == K_WAIT);
    ctrl_o.use_req   = word.use_req;
    ctrl_o.value     = word.value;
    ctrl_o.lo_half   = sub_q[1];
    ctrl_o.en        = ~sub_q[0];
    ctrl_o.wait_ms   = word.wait_ms;
    ctrl_o.last      = word.last && byte_done;
  end

endmodule

/* hw/rtl/clns_dpath.sv */
`timescale 1ns / 1ps
// Datapath: request byte and RS registers, strobe time register and the step output
// register. It depends on clns_pkg for the control word driven by the sequencer.
module clns_dpath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  clns_pkg::ctrl_t ctrl_i,
  input  logic [7:0]      byte_value_i,
  input  logic            cursor_row_i,
  input  logic [5:0]      cursor_column_i,
  input  logic            cfg_valid_i,
  input  logic [6:0]      cfg_data_i,
  input  logic            out_ready_i,
  output logic            out_adv_o,
  output logic            out_valid_o,
  output logic            drive_pins_o,
  output logic            register_select_o,
  output logic [3:0]      bus_nibble_o,
  output logic            enable_level_o,
  output logic [6:0]      hold_ms_o,
  output logic            last_step_o
);
  import clns_pkg::*;

  logic       rs_q;
  logic [7:0] byte_q;
  logic [6:0] strobe_q;
  logic       valid_q;
  logic       drive_q, sel_q, en_q, last_q;
  logic [3:0] nib_q;
  logic [6:0] hold_q;
  logic [7:0] cur_byte;
  logic [6:0] strobe_hold;

  assign cur_byte    = ctrl_i.use_req ? byte_q : ctrl_i.value;
  assign strobe_hold = (strobe_q > HoldMax) ? HoldMax : strobe_q;
  assign out_adv_o   = !valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rs_q   <= (ctrl_i.cmd == CMD_DATA);
      byte_q <= (ctrl_i.cmd == CMD_CURSOR) ? {1'b1, cursor_row_i, cursor_column_i}
                                           : byte_value_i;
    end
    if (ctrl_i.emit) begin
      last_q <= ctrl_i.last;
      if (ctrl_i.wait_step) begin
        drive_q <= 1'b0;
        sel_q   <= 1'b0;
        nib_q   <= 4'd0;
        en_q    <= 1'b0;
        hold_q  <= ctrl_i.wait_ms;
      end else begin
        drive_q <= 1'b1;
        sel_q   <= ctrl_i.use_req && rs_q;
        nib_q   <= ctrl_i.lo_half ? cur_byte[3:0] : cur_byte[7:4];
        en_q    <= ctrl_i.en;
        hold_q  <= strobe_hold;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= StrobeReset;
      valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        strobe_q <= cfg_data_i;
      end
      if (ctrl_i.emit) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = valid_q;
  assign drive_pins_o      = drive_q;
  assign register_select_o = sel_q;
  assign bus_nibble_o      = nib_q;
  assign enable_level_o    = en_q;
  assign hold_ms_o         = hold_q;
  assign last_step_o       = last_q;

endmodule

/* sim/tb_char_lcd_nibble_sequencer.sv */
`timescale 1ns / 1ps
// Self-checking testbench of char_lcd_nibble_sequencer: requests of every kind go in under
// several strobe times, and each pin step that comes out is compared with a local prediction.
// It depends on clns_pkg, the channel interfaces in clns_if.sv and the top level of the block.
module tb_char_lcd_nibble_sequencer;
  import clns_pkg::*;

  localparam logic [2:0]  CmdUnknownLo  = 3'd5;
  localparam logic [2:0]  CmdUnknownMid = 3'd6;
  localparam logic [2:0]  CmdUnknownHi  = 3'd7;
  localparam logic [7:0]  CursorRow0    = 8'h80;
  localparam logic [7:0]  CursorRow1    = 8'hC0;
  localparam logic [7:0]  ClearDisplay  = 8'h01;
  localparam logic [6:0]  ClearWaitMs   = 7'd2;
  localparam logic [6:0]  PowerUpWaitMs = 7'd50;
  localparam int unsigned PowerUpLen    = 9;
  localparam logic [71:0] PowerUpBytes  = 72'h0C_06_01_08_28_02_03_03_03;
  localparam logic [71:0] PowerUpWaits  = 72'h00_01_01_01_01_0A_0A_01_05;
  localparam int unsigned PhaseItems    = 25;
  localparam int unsigned RandomPhases  = 6;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned DrainCycles   = 60;
  localparam int unsigned QuietLimit    = 2000;

  typedef struct packed {
    logic       drive_pins;
    logic       register_select;
    logic [3:0] bus_nibble;
    logic       enable_level;
    logic [6:0] hold_ms;
    logic       last_step;
  } pin_step_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] bval;
    logic       row;
    logic [5:0] col;
    logic       typed;
    logic       silent;
    logic       sent_rs;
    logic [7:0] sent_byte;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  pin_step_t   pin_steps_due[$];
  logic [6:0]  strobe_ms = StrobeReset;
  int unsigned failures = 0;
  int unsigned quiet_cycles = 0;
  bit          tx_steady = 1'b0;

  clns_req_if  req_ch();
  clns_step_if step_ch();
  clns_cfg_if  cfg_ch();

  char_lcd_nibble_sequencer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .step_o (step_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_step(input logic drive, input logic rs, input logic [3:0] nib,
                                    input logic en, input logic [6:0] hold);
    pin_step_t s;
    s.drive_pins      = drive;
    s.register_select = rs;
    s.bus_nibble      = nib;
    s.enable_level    = en;
    s.hold_ms         = hold;
    s.last_step       = 1'b0;
    pin_steps_due.push_back(s);
  endfunction

  function automatic void push_byte(input logic rs, input logic [7:0] b);
    logic [6:0] hold;
    hold = (strobe_ms > HoldMax) ? HoldMax : strobe_ms;
    push_step(1'b1, rs, b[7:4], 1'b1, hold);
    push_step(1'b1, rs, b[7:4], 1'b0, hold);
    push_step(1'b1, rs, b[3:0], 1'b1, hold);
    push_step(1'b1, rs, b[3:0], 1'b0, hold);
  endfunction

  function automatic void expand_request(input logic [2:0] cmd, input logic [7:0] bval,
                                         input logic row, input logic [5:0] col);
    int unsigned i;
    case (cmd)
      CMD_DATA:   push_byte(1'b1, bval);
      CMD_INSTR:  push_byte(1'b0, bval);
      CMD_CURSOR: push_byte(1'b0, (row ? CursorRow1 : CursorRow0) | {2'b00, col});
      CMD_CLEAR: begin
        push_byte(1'b0, ClearDisplay);
        push_step(1'b0, 1'b0, 4'h0, 1'b0, ClearWaitMs);
      end
      CMD_INIT: begin
        push_step(1'b0, 1'b0, 4'h0, 1'b0, PowerUpWaitMs);
        for (i = 0; i < PowerUpLen; i++) begin
          push_byte(1'b0, PowerUpBytes[i*8 +: 8]);
          if (PowerUpWaits[i*8 +: 8] != 8'd0) begin
            push_step(1'b0, 1'b0, 4'h0, 1'b0, PowerUpWaits[i*8 +: 7]);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic stim_row_t random_request();
    stim_row_t   r;
    int unsigned pick;
    r      = '0;
    r.bval = 8'($urandom);
    r.row  = 1'($urandom);
    r.col  = 6'($urandom);
    pick   = $urandom_range(0, 99);
    if (pick < 35) r.cmd = CMD_DATA;
    else if (pick < 60) r.cmd = CMD_INSTR;
    else if (pick < 80) r.cmd = CMD_CURSOR;
    else if (pick < 88) r.cmd = CMD_CLEAR;
    else if (pick < 94) r.cmd = CMD_INIT;
    else r.cmd = 3'($urandom_range(CmdUnknownLo, CmdUnknownHi));
    return r;
  endfunction

  task automatic issue_request(input stim_row_t r);
    int unsigned gap;
    int unsigned start;
    if ($urandom_range(0, 24) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid         <= 1'b1;
    req_ch.command       <= r.cmd;
    req_ch.byte_value    <= r.bval;
    req_ch.cursor_row    <= r.row;
    req_ch.cursor_column <= r.col;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    start = pin_steps_due.size();
    if (!r.typed) begin
      expand_request(r.cmd, r.bval, r.row, r.col);
    end else if (!r.silent) begin
      push_byte(r.sent_rs, r.sent_byte);
    end
    if (pin_steps_due.size() > start) begin
      pin_steps_due[pin_steps_due.size() - 1].last_step = 1'b1;
    end
  endtask

  task automatic quiesce(input int unsigned settle);
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (pin_steps_due.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_strobe(input logic [6:0] level);
    @(negedge clk_i);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.strobe_hold_ms <= level;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    strobe_ms = level;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int unsigned rx_stall_left;
    bit          rx_steady;
    rx_stall_left = 0;
    rx_steady     = 1'b0;
    step_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 149) == 0) rx_steady = !rx_steady;
      if (rx_stall_left != 0) begin
        step_ch.ready <= 1'b0;
        rx_stall_left--;
      end else begin
        step_ch.ready <= 1'b1;
        if (!rx_steady) rx_stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    pin_step_t got;
    pin_step_t want;
    if (rst_ni && step_ch.valid && step_ch.ready) begin
      got.drive_pins      = step_ch.drive_pins;
      got.register_select = step_ch.register_select;
      got.bus_nibble      = step_ch.bus_nibble;
      got.enable_level    = step_ch.enable_level;
      got.hold_ms         = step_ch.hold_ms;
      got.last_step       = step_ch.last_step;
      if (pin_steps_due.size() == 0) begin
        $error("pin step with no request pending: %p", got);
        failures++;
      end else begin
        want = pin_steps_due.pop_front();
        if (got.drive_pins !== want.drive_pins) begin
          $error("drive_pins: expected %0d, got %0d", want.drive_pins, got.drive_pins);
          failures++;
        end
        if (got.register_select !== want.register_select) begin
          $error("register_select: expected %0d, got %0d", want.register_select,
                 got.register_select);
          failures++;
        end
        if (got.bus_nibble !== want.bus_nibble) begin
          $error("bus_nibble: expected %h, got %h", want.bus_nibble, got.bus_nibble);
          failures++;
        end
        if (got.enable_level !== want.enable_level) begin
          $error("enable_level: expected %0d, got %0d", want.enable_level, got.enable_level);
          failures++;
        end
        if (got.hold_ms !== want.hold_ms) begin
          $error("hold_ms: expected %0d, got %0d", want.hold_ms, got.hold_ms);
          failures++;
        end
        if (got.last_step !== want.last_step) begin
          $error("last_step: expected %0d, got %0d", want.last_step, got.last_step);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (step_ch.valid && step_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t   directed_rows [20];
    stim_row_t   r;
    int unsigned counted;
    int unsigned phase;
    logic [6:0]  level;

    // cmd, byte, row, column, typed, silent, RS sent, byte sent
    directed_rows = '{
      '{CMD_DATA,      8'h00, 1'b0, 6'd0,  1'b1, 1'b0, 1'b1, 8'h00},
      '{CMD_DATA,      8'hFF, 1'b0, 6'd0,  1'b1, 1'b0, 1'b1, 8'hFF},
      '{CMD_DATA,      8'hA5, 1'b0, 6'd0,  1'b1, 1'b0, 1'b1, 8'hA5},
      '{CMD_DATA,      8'h5A, 1'b1, 6'd63, 1'b1, 1'b0, 1'b1, 8'h5A},
      '{CMD_INSTR,     8'h00, 1'b0, 6'd0,  1'b1, 1'b0, 1'b0, 8'h00},
      '{CMD_INSTR,     8'hFF, 1'b1, 6'd63, 1'b1, 1'b0, 1'b0, 8'hFF},
      '{CMD_INSTR,     8'h3C, 1'b0, 6'd0,  1'b1, 1'b0, 1'b0, 8'h3C},
      '{CMD_CURSOR,    8'hFF, 1'b0, 6'd0,  1'b1, 1'b0, 1'b0, 8'h80},
      '{CMD_CURSOR,    8'h00, 1'b0, 6'd63, 1'b1, 1'b0, 1'b0, 8'hBF},
      '{CMD_CURSOR,    8'hFF, 1'b1, 6'd0,  1'b1, 1'b0, 1'b0, 8'hC0},
      '{CMD_CURSOR,    8'h00, 1'b1, 6'd63, 1'b1, 1'b0, 1'b0, 8'hFF},
      '{CMD_CURSOR,    8'h55, 1'b1, 6'd42, 1'b0, 1'b0, 1'b0, 8'h00},
      '{CMD_CLEAR,     8'hFF, 1'b1, 6'd63, 1'b0, 1'b0, 1'b0, 8'h00},
      '{CMD_INIT,      8'h00, 1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 8'h00},
      '{CmdUnknownLo,  8'hFF, 1'b0, 6'd0,  1'b1, 1'b1, 1'b0, 8'h00},
      '{CmdUnknownMid, 8'h00, 1'b1, 6'd63, 1'b1, 1'b1, 1'b0, 8'h00},
      '{CmdUnknownHi,  8'hFF, 1'b1, 6'd63, 1'b1, 1'b1, 1'b0, 8'h00},
      '{CMD_DATA,      8'h41, 1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 8'h00},
      '{CMD_INIT,      8'hFF, 1'b1, 6'd63, 1'b0, 1'b0, 1'b0, 8'h00},
      '{CMD_CLEAR,     8'h00, 1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 8'h00}
    };

    req_ch.valid          = 1'b0;
    req_ch.command        = CMD_DATA;
    req_ch.byte_value     = 8'h00;
    req_ch.cursor_row     = 1'b0;
    req_ch.cursor_column  = 6'd0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.strobe_hold_ms = StrobeReset;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) issue_request(directed_rows[i]);

    for (phase = 0; phase < RandomPhases; phase++) begin
      quiesce(SettleCycles);
      case (phase)
        0:       level = 7'd0;
        1:       level = 7'd127;
        2:       level = HoldMax;
        3:       level = HoldMax + 7'd1;
        4:       level = StrobeReset;
        default: level = 7'($urandom_range(2, 99));
      endcase
      write_strobe(level);
      counted = 0;
      while (counted < PhaseItems) begin
        r = random_request();
        issue_request(r);
        if (r.cmd <= CMD_CLEAR) counted++;
      end
    end

    quiesce(DrainCycles);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
